/* rtl/scan_point_clusterer_core_macros.svh */
// Assertion macros shared by the clusterer RTL.
`ifndef SCAN_POINT_CLUSTERER_CORE_MACROS_SVH
`define SCAN_POINT_CLUSTERER_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SPC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define SPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define SPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/spc_pkg.sv */
package spc_pkg;

	// Default build parameters.
	localparam int MAX_SCAN_POINTS_DEF = 4096;
	localparam int COORD_BITS_DEF      = 16;

	// Fixed register widths.
	localparam int THR_W      = 16;
	localparam int MIN_W      = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_DIST_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE       = 1'b1;

	// Register reset values.
	localparam logic [THR_W-1:0]   DIST_THRESHOLD_RST = 16'd100;
	localparam logic [MIN_W-1:0]   MIN_SIZE_RST       = 12'd5;
	localparam logic [2*THR_W-1:0] THR_SQ_RST         =
		(2*THR_W)'(int'(DIST_THRESHOLD_RST) * int'(DIST_THRESHOLD_RST));

	// Kept-cluster counter saturates once a wrap merge becomes possible.
	localparam logic [1:0] KEPT_NONE = 2'd0;
	localparam logic [1:0] KEPT_SAT  = 2'd2;

	// Result queue.
	localparam int FIFO_DEPTH   = 32;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W   = FIFO_AW + 1;
	localparam int RES_PER_ITEM = 3;

endpackage

/* rtl/scan_point_clusterer_core.sv */
// An accepted point request passes through stages s1 to s5; its results then enter the queue.
// Throughput, unless stalled: one point in and one result out per cycle; 32-entry queue.
// Input stalls only when the queue lacks room for three results per new or in-flight point.
// Reset (arst_n low, asynchronous): registers to defaults, scan state and queue cleared.
`include "scan_point_clusterer_core_macros.svh"

module scan_point_clusterer_core #(
	parameter int MAX_SCAN_POINTS = spc_pkg::MAX_SCAN_POINTS_DEF,
	parameter int COORD_BITS      = spc_pkg::COORD_BITS_DEF,
	localparam int IDX_W          = $clog2(MAX_SCAN_POINTS),
	localparam int CNT_W          = $clog2(MAX_SCAN_POINTS + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [COORD_BITS-1:0]        point_x,
	input  logic signed [COORD_BITS-1:0]        point_y,
	input  logic                                end_of_scan,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                cluster_valid,
	output logic [IDX_W-1:0]                    start_index,
	output logic [CNT_W-1:0]                    point_count,
	output logic                                wraps_first,
	output logic                                last_of_scan,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [spc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [spc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import spc_pkg::*;

	localparam int D_W    = COORD_BITS + 1;
	localparam int SQ_W   = 2 * D_W;
	localparam int SS_W   = SQ_W + 1;
	localparam int DC_W   = (SS_W > 2 * THR_W) ? SS_W : 2 * THR_W;
	localparam int CMP_W  = (CNT_W > MIN_W) ? CNT_W : MIN_W;
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_SCAN_POINTS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SCAN_POINTS - 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic             cluster_valid;
		logic [IDX_W-1:0] start;
		logic [CNT_W-1:0] count;
		logic             wraps;
		logic             last;
	} res_t;

	// Magnitude of the difference of two coordinates, exact in one extra bit.
	function automatic logic [D_W-1:0] abs_diff(input coord_t a, input coord_t b);
		logic signed [D_W-1:0] d;
		d = D_W'(a) - D_W'(b);
		return d[D_W-1] ? D_W'(-d) : D_W'(d);
	endfunction

	// A closed cluster is kept when its count exceeds the minimum.
	function automatic logic keeps(input logic [CNT_W-1:0] cnt, input logic [MIN_W-1:0] lim);
		return CMP_W'(cnt) > CMP_W'(lim);
	endfunction

	// Configuration registers and the squared threshold.
	logic [THR_W-1:0]   thr_q;
	logic [MIN_W-1:0]   min_q;
	logic [2*THR_W-1:0] thr_sq_q;

	// Pipeline control and payload.
	logic                 accept;
	logic                 valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	coord_t               prev_x_q, prev_y_q;
	coord_t               x_s1, y_s1, px_s1, py_s1;
	coord_t               x_s2, y_s2, px_s2, py_s2;
	coord_t               x_s3, y_s3, px_s3, py_s3;
	logic                 eos_s1, eos_s2, eos_s3, eos_s4, eos_s5;
	logic [SQ_W-1:0]      sqx_s2, sqy_s2;
	logic [SS_W-1:0]      dist_sum;
	logic                 near_s3;

	// Scan state.
	logic [IDX_W-1:0] point_index_q, cur_start_q, pend_start_q;
	logic [CNT_W-1:0] cur_count_q, pend_count_q, head_count_q;
	logic             pend_valid_q;
	coord_t           pend_last_x_q, pend_last_y_q, head_first_x_q, head_first_y_q;
	logic [1:0]       kept_q;

	// State after one point, before the end-of-scan clear.
	logic [IDX_W-1:0] w_start, w_ps;
	logic [CNT_W-1:0] w_count, w_pc, w_hc;
	logic             w_pv;
	coord_t           w_plx, w_ply, w_hx, w_hy;
	logic [1:0]       w_kept;
	logic             ea_v, eb_v;
	logic [IDX_W-1:0] ea_start, eb_start;
	logic [CNT_W-1:0] ea_count, eb_count;

	// Emission stages.
	logic             ea_v_s4, eb_v_s4, ea_v_s5, eb_v_s5;
	logic [IDX_W-1:0] ea_start_s4, eb_start_s4, fin_start_s4;
	logic [IDX_W-1:0] ea_start_s5, eb_start_s5, fin_start_s5;
	logic [CNT_W-1:0] ea_count_s4, eb_count_s4, fin_count_s4, fin_hc_s4;
	logic [CNT_W-1:0] ea_count_s5, eb_count_s5, fin_count_s5, fin_hc_s5;
	logic             fin_v_s4, fin_multi_s4, fin_v_s5, fin_multi_s5;
	coord_t           fin_hx_s4, fin_hy_s4, fin_lx_s4, fin_ly_s4;
	logic [SQ_W-1:0]  hsqx_s5, hsqy_s5;

	// Result queue.
	res_t                  fifo_mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] fifo_count_q;
	res_t                  cand [RES_PER_ITEM];
	logic                  cand_v [RES_PER_ITEM];
	logic [FIFO_AW-1:0]    cand_off [RES_PER_ITEM];
	logic [1:0]            push_n;
	logic                  pop;
	logic                  wrap_near;
	logic                  wraps;
	logic [CNT_W:0]        merged;
	logic [CNT_W-1:0]      merged_sat;
	logic [2:0]            inflight;
	logic [6:0]            reserve;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= DIST_THRESHOLD_RST;
			min_q    <= MIN_SIZE_RST;
			thr_sq_q <= THR_SQ_RST;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_DIST_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
					REG_MIN_SIZE:       min_q <= cfg_data[MIN_W-1:0];
					default:            ;
				endcase
			end
			thr_sq_q <= (2*THR_W)'(thr_q) * (2*THR_W)'(thr_q);
		end
	end

	// Input flow control reserves queue room for every point in flight.
	assign inflight = 3'(valid_s1) + 3'(valid_s2) + 3'(valid_s3) + 3'(valid_s4) + 3'(valid_s5);
	assign reserve  = 7'(fifo_count_q) + 7'(RES_PER_ITEM) * (7'(inflight) + 7'd1);
	assign in_stall = reserve > 7'(FIFO_DEPTH);
	assign accept   = in_valid && !in_stall;

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			if (accept) begin
				prev_x_q <= point_x;
				prev_y_q <= point_y;
			end
		end
	end

	// Stage 1 registers the point with its predecessor, stage 2 squares the gaps, stage 3 tests the sum.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1   <= point_x;
			y_s1   <= point_y;
			px_s1  <= prev_x_q;
			py_s1  <= prev_y_q;
			eos_s1 <= end_of_scan;
		end
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		px_s2  <= px_s1;
		py_s2  <= py_s1;
		eos_s2 <= eos_s1;
		sqx_s2 <= SQ_W'(abs_diff(x_s1, px_s1)) * SQ_W'(abs_diff(x_s1, px_s1));
		sqy_s2 <= SQ_W'(abs_diff(y_s1, py_s1)) * SQ_W'(abs_diff(y_s1, py_s1));
		x_s3    <= x_s2;
		y_s3    <= y_s2;
		px_s3   <= px_s2;
		py_s3   <= py_s2;
		eos_s3  <= eos_s2;
		near_s3 <= DC_W'(dist_sum) < DC_W'(thr_sq_q);
	end

	assign dist_sum = SS_W'(sqx_s2) + SS_W'(sqy_s2);

	// Cluster bookkeeping for the point in stage 3.
	always_comb begin
		w_start  = cur_start_q;
		w_count  = cur_count_q;
		w_pv     = pend_valid_q;
		w_ps     = pend_start_q;
		w_pc     = pend_count_q;
		w_plx    = pend_last_x_q;
		w_ply    = pend_last_y_q;
		w_kept   = kept_q;
		w_hc     = head_count_q;
		w_hx     = head_first_x_q;
		w_hy     = head_first_y_q;
		ea_v     = 1'b0;
		ea_start = pend_start_q;
		ea_count = pend_count_q;
		eb_v     = 1'b0;
		eb_start = pend_start_q;
		eb_count = pend_count_q;
		if (cur_count_q == '0) begin
			// First point of a scan opens a cluster without a distance test.
			w_start = point_index_q;
			w_count = CNT_W'(1);
			if (kept_q == KEPT_NONE) begin
				w_hx = x_s3;
				w_hy = y_s3;
			end
		end else if (near_s3) begin
			if (cur_count_q < CNT_MAX) begin
				w_count = cur_count_q + CNT_W'(1);
			end
		end else begin
			// A break closes the current cluster at the previous point.
			if (keeps(cur_count_q, min_q)) begin
				ea_v     = pend_valid_q;
				ea_start = pend_start_q;
				ea_count = pend_count_q;
				w_pv     = 1'b1;
				w_ps     = cur_start_q;
				w_pc     = cur_count_q;
				w_plx    = px_s3;
				w_ply    = py_s3;
				if (kept_q == KEPT_NONE) begin
					w_hc = cur_count_q;
				end
				if (kept_q != KEPT_SAT) begin
					w_kept = kept_q + 2'd1;
				end
			end
			w_start = point_index_q;
			w_count = CNT_W'(1);
			if (w_kept == KEPT_NONE) begin
				w_hx = x_s3;
				w_hy = y_s3;
			end
		end
		if (eos_s3) begin
			// The end of the scan closes the open cluster at this point.
			if (keeps(w_count, min_q)) begin
				eb_v     = w_pv;
				eb_start = w_ps;
				eb_count = w_pc;
				w_pv     = 1'b1;
				w_ps     = w_start;
				w_pc     = w_count;
				w_plx    = x_s3;
				w_ply    = y_s3;
				if (w_kept == KEPT_NONE) begin
					w_hc = w_count;
				end
				if (w_kept != KEPT_SAT) begin
					w_kept = w_kept + 2'd1;
				end
			end
		end
	end

	// Scan state registers; the end of a scan returns them to their reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_index_q  <= '0;
			cur_start_q    <= '0;
			cur_count_q    <= '0;
			pend_valid_q   <= 1'b0;
			pend_start_q   <= '0;
			pend_count_q   <= '0;
			pend_last_x_q  <= '0;
			pend_last_y_q  <= '0;
			kept_q         <= KEPT_NONE;
			head_count_q   <= '0;
			head_first_x_q <= '0;
			head_first_y_q <= '0;
		end else if (valid_s3) begin
			if (eos_s3) begin
				point_index_q  <= '0;
				cur_start_q    <= '0;
				cur_count_q    <= '0;
				pend_valid_q   <= 1'b0;
				pend_start_q   <= '0;
				pend_count_q   <= '0;
				pend_last_x_q  <= '0;
				pend_last_y_q  <= '0;
				kept_q         <= KEPT_NONE;
				head_count_q   <= '0;
				head_first_x_q <= '0;
				head_first_y_q <= '0;
			end else begin
				point_index_q  <= (point_index_q == IDX_LAST) ? '0 :
					point_index_q + IDX_W'(1);
				cur_start_q    <= w_start;
				cur_count_q    <= w_count;
				pend_valid_q   <= w_pv;
				pend_start_q   <= w_ps;
				pend_count_q   <= w_pc;
				pend_last_x_q  <= w_plx;
				pend_last_y_q  <= w_ply;
				kept_q         <= w_kept;
				head_count_q   <= w_hc;
				head_first_x_q <= w_hx;
				head_first_y_q <= w_hy;
			end
		end
	end

	// Stage 4 holds the emissions, stage 5 carries them on with the squared gap for the wrap test.
	always_ff @(posedge clk) begin
		eos_s4       <= eos_s3;
		ea_v_s4      <= ea_v;
		ea_start_s4  <= ea_start;
		ea_count_s4  <= ea_count;
		eb_v_s4      <= eb_v;
		eb_start_s4  <= eb_start;
		eb_count_s4  <= eb_count;
		fin_v_s4     <= w_pv;
		fin_start_s4 <= w_pv ? w_ps : '0;
		fin_count_s4 <= w_pv ? w_pc : '0;
		fin_hc_s4    <= w_hc;
		fin_multi_s4 <= w_kept == KEPT_SAT;
		fin_hx_s4    <= w_hx;
		fin_hy_s4    <= w_hy;
		fin_lx_s4    <= w_plx;
		fin_ly_s4    <= w_ply;
		eos_s5       <= eos_s4;
		ea_v_s5      <= ea_v_s4;
		ea_start_s5  <= ea_start_s4;
		ea_count_s5  <= ea_count_s4;
		eb_v_s5      <= eb_v_s4;
		eb_start_s5  <= eb_start_s4;
		eb_count_s5  <= eb_count_s4;
		fin_v_s5     <= fin_v_s4;
		fin_start_s5 <= fin_start_s4;
		fin_count_s5 <= fin_count_s4;
		fin_hc_s5    <= fin_hc_s4;
		fin_multi_s5 <= fin_multi_s4;
		hsqx_s5      <= SQ_W'(abs_diff(fin_hx_s4, fin_lx_s4)) *
			SQ_W'(abs_diff(fin_hx_s4, fin_lx_s4));
		hsqy_s5      <= SQ_W'(abs_diff(fin_hy_s4, fin_ly_s4)) *
			SQ_W'(abs_diff(fin_hy_s4, fin_ly_s4));
	end

	// Wrap test and merged count for the final result.
	assign wrap_near  = DC_W'(SS_W'(hsqx_s5) + SS_W'(hsqy_s5)) < DC_W'(thr_sq_q);
	assign wraps      = fin_v_s5 && fin_multi_s5 && wrap_near;
	assign merged     = (CNT_W+1)'(fin_count_s5) + (CNT_W+1)'(fin_hc_s5);
	assign merged_sat = (merged > (CNT_W+1)'(CNT_MAX)) ? CNT_MAX : merged[CNT_W-1:0];

	// Up to three results per point, packed into consecutive queue slots.
	always_comb begin
		cand[0]     = '{cluster_valid: 1'b1, start: ea_start_s5, count: ea_count_s5,
			wraps: 1'b0, last: 1'b0};
		cand[1]     = '{cluster_valid: 1'b1, start: eb_start_s5, count: eb_count_s5,
			wraps: 1'b0, last: 1'b0};
		cand[2]     = '{cluster_valid: fin_v_s5, start: fin_start_s5,
			count: wraps ? merged_sat : fin_count_s5, wraps: wraps, last: 1'b1};
		cand_v[0]   = valid_s5 && ea_v_s5;
		cand_v[1]   = valid_s5 && eb_v_s5;
		cand_v[2]   = valid_s5 && eos_s5;
		cand_off[0] = '0;
		cand_off[1] = FIFO_AW'(cand_v[0]);
		cand_off[2] = FIFO_AW'(cand_v[0]) + FIFO_AW'(cand_v[1]);
		push_n      = 2'(cand_v[0]) + 2'(cand_v[1]) + 2'(cand_v[2]);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < RES_PER_ITEM; i++) begin
			if (cand_v[i]) begin
				fifo_mem[wr_ptr_q + cand_off[i]] <= cand[i];
			end
		end
	end

	// Queue pointers and occupancy.
	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			fifo_count_q <= '0;
		end else begin
			wr_ptr_q     <= wr_ptr_q + FIFO_AW'(push_n);
			rd_ptr_q     <= rd_ptr_q + FIFO_AW'(pop);
			fifo_count_q <= fifo_count_q + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
		end
	end

	// The queue head drives the output request.
	assign out_valid     = fifo_count_q != '0;
	assign cluster_valid = fifo_mem[rd_ptr_q].cluster_valid;
	assign start_index   = fifo_mem[rd_ptr_q].start;
	assign point_count   = fifo_mem[rd_ptr_q].count;
	assign wraps_first   = fifo_mem[rd_ptr_q].wraps;
	assign last_of_scan  = fifo_mem[rd_ptr_q].last;

	// Checks on the queue reservation and the scan state.
	`SPC_ASSERT_SAME(a_push_room, clk, arst_n, valid_s5, (int'(fifo_count_q) + int'(push_n)) <= FIFO_DEPTH, "result queue would overflow")
	`SPC_ASSERT_ALWAYS(a_pend_kept, clk, arst_n, pend_valid_q == (kept_q != KEPT_NONE), "pending cluster and kept count disagree")
	`SPC_ASSERT_ALWAYS(a_kept_sat, clk, arst_n, kept_q <= KEPT_SAT, "kept cluster count beyond saturation")
	`SPC_ASSERT_NEXT(a_scan_clear, clk, arst_n, valid_s3 && eos_s3, (cur_count_q == '0) && !pend_valid_q && (point_index_q == '0), "scan state not cleared after end of scan")

endmodule
